[hw/rtl/stt_pkg.sv]
// stt_pkg: shared constants and types for the software timer table
// no dependencies
package stt_pkg;

  localparam int TIMER_COUNT_DEF   = 16;
  localparam int TIME_BITS_DEF     = 32;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int STAMP_BITS        = 16;

  localparam logic [2:0] OP_CREATE    = 3'd0;
  localparam logic [2:0] OP_DELETE    = 3'd1;
  localparam logic [2:0] OP_CONFIGURE = 3'd2;
  localparam logic [2:0] OP_START     = 3'd3;
  localparam logic [2:0] OP_STOP      = 3'd4;
  localparam logic [2:0] OP_TICK      = 3'd5;
  localparam logic [2:0] OP_POP       = 3'd6;

  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_ALREADY     = 2'd1;
  localparam logic [1:0] ERR_NOT_CREATED = 2'd2;
  localparam logic [1:0] ERR_STATUS      = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

[hw/rtl/stt_ram.sv]
// stt_ram: generic single-port-write, single-read synchronous ram
// registered read, no dependencies
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/software_timer_table.sv]
// software_timer_table: table of one-shot/periodic timers in an entry memory
// uses stt_pkg and stt_ram
//
// Usage: drive in_* and raise start while busy is low; that edge takes the
// transaction. The block raises busy and answers with exactly one result on
// out_* marked by out_valid for one cycle; the receiver cannot stall.
// Create/delete/configure/start/stop read the entry memory, modify, write
// back and answer. Tick and pop sweep the entry memory one entry per cycle.
// Status bits (created, active, queued, mode) sit in flip-flops that reset
// clears; period, match, priority, expiry time and queue stamp sit in the
// memory and need no clearing. Pop finds its winner during the sweep and
// reads the winner's expiry in the final cycle from a registered copy.
// After reset the block is idle and ready at once.
// One transaction at a time; busy is high from acceptance until the result.
module software_timer_table #(
  parameter int TIMER_COUNT   = stt_pkg::TIMER_COUNT_DEF,
  parameter int TIME_BITS     = stt_pkg::TIME_BITS_DEF,
  parameter int PRIORITY_BITS = stt_pkg::PRIORITY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_timer_index,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_period_ticks,
  input  logic [31:0] in_lag_ticks,
  input  logic [7:0]  in_priority_req,
  output logic        out_valid,
  output logic        out_ok,
  output logic [1:0]  out_error_code,
  output logic [4:0]  out_expired_count,
  output logic        out_expire_pending,
  output logic        out_popped_valid,
  output logic [3:0]  out_popped_index,
  output logic [31:0] out_drift_ticks
);
  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CW = $clog2(TIMER_COUNT + 1);
  localparam int SB = stt_pkg::STAMP_BITS;
  localparam int EW = 3 * TIME_BITS + PRIORITY_BITS + SB;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  stt_pkg::state_t state_r, state_nxt;

  logic [2:0]            op_r, op_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  exists_r, exists_nxt;
  logic [1:0]            mode_in_r, mode_in_nxt;
  logic [TIME_BITS-1:0]  per_in_r, per_in_nxt;
  logic [TIME_BITS-1:0]  lag_in_r, lag_in_nxt;
  logic [PRIORITY_BITS-1:0] pri_in_r, pri_in_nxt;

  logic [TIME_BITS-1:0]  time_r, time_nxt;
  logic [SB-1:0]         stamp_r, stamp_nxt;
  logic [TIMER_COUNT-1:0] ready_r, ready_nxt;
  logic [TIMER_COUNT-1:0] active_r, active_nxt;
  logic [TIMER_COUNT-1:0] queued_r, queued_nxt;
  logic [1:0]            emode_r [TIMER_COUNT];
  logic [1:0]            emode_nxt [TIMER_COUNT];

  logic [IW-1:0]         rptr_r, rptr_nxt;
  logic [CW-1:0]         rcnt_r, rcnt_nxt;
  logic                  rvalid_r, rvalid_nxt;
  logic [IW-1:0]         cptr_r, cptr_nxt;
  logic [CW-1:0]         count_r, count_nxt;

  logic                  found_r, found_nxt;
  logic [IW-1:0]         best_r, best_nxt;
  logic [PRIORITY_BITS-1:0] bpri_r, bpri_nxt;
  logic [SB-1:0]         bage_r, bage_nxt;
  logic [TIME_BITS-1:0]  bexp_r, bexp_nxt;

  logic                  ok_r, ok_nxt;
  logic [1:0]            err_r, err_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic                  opv_r, opv_nxt;
  logic [3:0]            opidx_r, opidx_nxt;
  logic [31:0]           drift_r, drift_nxt;
  logic [4:0]            ocnt_r, ocnt_nxt;
  logic                  opend_r, opend_nxt;

  logic                  we;
  logic [IW-1:0]         waddr, raddr;
  logic [EW-1:0]         wdata, rdata;

  logic [TIME_BITS-1:0]  e_per, e_match, e_exp;
  logic [PRIORITY_BITS-1:0] e_pri;
  logic [SB-1:0]         e_stamp;
  logic [TIME_BITS-1:0]  w_per, w_match, w_exp;
  logic [PRIORITY_BITS-1:0] w_pri;
  logic [SB-1:0]         w_stamp;
  logic [SB-1:0]         age;
  logic [TIME_BITS-1:0]  drift_full;

  assign {e_per, e_match, e_exp, e_pri, e_stamp} = rdata;
  assign wdata = {w_per, w_match, w_exp, w_pri, w_stamp};
  assign age = stamp_r - e_stamp;

  stt_ram #(.WIDTH(EW), .DEPTH(TIMER_COUNT)) u_entry_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    idx_nxt     = idx_r;
    exists_nxt  = exists_r;
    mode_in_nxt = mode_in_r;
    per_in_nxt  = per_in_r;
    lag_in_nxt  = lag_in_r;
    pri_in_nxt  = pri_in_r;
    time_nxt    = time_r;
    stamp_nxt   = stamp_r;
    ready_nxt   = ready_r;
    active_nxt  = active_r;
    queued_nxt  = queued_r;
    emode_nxt   = emode_r;
    rptr_nxt    = rptr_r;
    rcnt_nxt    = rcnt_r;
    rvalid_nxt  = 1'b0;
    cptr_nxt    = cptr_r;
    count_nxt   = count_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    bpri_nxt    = bpri_r;
    bage_nxt    = bage_r;
    bexp_nxt    = bexp_r;
    ok_nxt      = ok_r;
    err_nxt     = err_r;
    ovalid_nxt  = 1'b0;
    opv_nxt     = 1'b0;
    opidx_nxt   = '0;
    drift_nxt   = '0;
    ocnt_nxt    = '0;
    opend_nxt   = opend_r;
    we          = 1'b0;
    waddr       = cptr_r;
    raddr       = rptr_r;
    w_per       = e_per;
    w_match     = e_match;
    w_exp       = e_exp;
    w_pri       = e_pri;
    w_stamp     = e_stamp;
    drift_full  = '0;

    unique case (state_r)
      stt_pkg::ST_IDLE: begin
        if (start && !busy) begin
          op_nxt      = in_opcode;
          exists_nxt  = 32'(in_timer_index) < TIMER_COUNT;
          idx_nxt     = IW'(in_timer_index);
          mode_in_nxt = in_mode;
          per_in_nxt  = TIME_BITS'(in_period_ticks);
          lag_in_nxt  = TIME_BITS'(in_lag_ticks);
          pri_in_nxt  = PRIORITY_BITS'(in_priority_req);
          ok_nxt      = 1'b0;
          err_nxt     = stt_pkg::ERR_NONE;
          count_nxt   = '0;
          found_nxt   = 1'b0;
          if (in_opcode == stt_pkg::OP_TICK || in_opcode == stt_pkg::OP_POP) begin
            if (in_opcode == stt_pkg::OP_TICK) begin
              time_nxt = time_r + 1'b1;
            end
            rptr_nxt   = '0;
            rcnt_nxt   = CW'(1);
            rvalid_nxt = 1'b1;
            cptr_nxt   = '0;
            raddr      = '0;
            state_nxt  = stt_pkg::ST_SCAN;
          end else begin
            raddr     = IW'(in_timer_index);
            state_nxt = stt_pkg::ST_READ;
          end
        end
      end
      stt_pkg::ST_READ: begin
        raddr     = idx_r;
        state_nxt = stt_pkg::ST_MOD;
      end
      stt_pkg::ST_MOD: begin
        waddr = idx_r;
        priority case (op_r)
          stt_pkg::OP_CREATE: begin
            if (!exists_r) begin
              err_nxt = stt_pkg::ERR_NOT_CREATED;
            end else if (ready_r[idx_r]) begin
              err_nxt = stt_pkg::ERR_ALREADY;
            end else begin
              ok_nxt            = 1'b1;
              ready_nxt[idx_r]  = 1'b1;
              active_nxt[idx_r] = 1'b0;
              queued_nxt[idx_r] = 1'b0;
              emode_nxt[idx_r]  = mode_in_r;
              we      = 1'b1;
              w_per   = per_in_r;
              w_pri   = pri_in_r;
              w_match = '0;
              w_exp   = '0;
            end
          end
          stt_pkg::OP_DELETE, stt_pkg::OP_CONFIGURE,
          stt_pkg::OP_START, stt_pkg::OP_STOP: begin
            if (!exists_r || !ready_r[idx_r]) begin
              err_nxt = stt_pkg::ERR_NOT_CREATED;
            end else if ((op_r == stt_pkg::OP_STOP) != active_r[idx_r]) begin
              err_nxt = stt_pkg::ERR_STATUS;
            end else begin
              ok_nxt = 1'b1;
              priority case (op_r)
                stt_pkg::OP_DELETE: begin
                  ready_nxt[idx_r]  = 1'b0;
                  active_nxt[idx_r] = 1'b0;
                  queued_nxt[idx_r] = 1'b0;
                  emode_nxt[idx_r]  = '0;
                end
                stt_pkg::OP_CONFIGURE: begin
                  we    = 1'b1;
                  w_per = per_in_r;
                  w_pri = pri_in_r;
                end
                stt_pkg::OP_START: begin
                  we      = 1'b1;
                  w_match = time_r + e_per + lag_in_r;
                  active_nxt[idx_r] = 1'b1;
                end
                default: begin
                  queued_nxt[idx_r] = 1'b0;
                  active_nxt[idx_r] = 1'b0;
                end
              endcase
            end
          end
          default: begin
          end
        endcase
        state_nxt = stt_pkg::ST_DONE;
      end
      stt_pkg::ST_SCAN: begin
        if (32'(rcnt_r) < TIMER_COUNT) begin
          rptr_nxt   = rptr_r + 1'b1;
          raddr      = rptr_r + 1'b1;
          rcnt_nxt   = rcnt_r + 1'b1;
          rvalid_nxt = 1'b1;
        end
        if (rvalid_r) begin
          cptr_nxt = cptr_r + 1'b1;
          if (op_r == stt_pkg::OP_TICK) begin
            if (ready_r[cptr_r] && active_r[cptr_r] && e_match == time_r) begin
              we = 1'b1;
              if (!queued_r[cptr_r]) begin
                queued_nxt[cptr_r] = 1'b1;
                w_exp     = e_match;
                w_stamp   = stamp_r;
                stamp_nxt = stamp_r + 1'b1;
                count_nxt = count_r + 1'b1;
              end
              if (emode_r[cptr_r][0]) begin
                w_match = e_match + e_per;
              end else begin
                active_nxt[cptr_r] = 1'b0;
              end
            end
          end else if (queued_r[cptr_r]) begin
            if (!found_r || e_pri < bpri_r || (e_pri == bpri_r && age > bage_r)) begin
              found_nxt = 1'b1;
              best_nxt  = cptr_r;
              bpri_nxt  = e_pri;
              bage_nxt  = age;
              bexp_nxt  = e_exp;
            end
          end
        end else begin
          state_nxt = stt_pkg::ST_DONE;
        end
      end
      stt_pkg::ST_DONE: begin
        ovalid_nxt = 1'b1;
        if (op_r == stt_pkg::OP_TICK) begin
          ok_nxt   = 1'b1;
          ocnt_nxt = 5'(count_r);
        end else if (op_r == stt_pkg::OP_POP && found_r) begin
          ok_nxt    = 1'b1;
          opv_nxt   = 1'b1;
          opidx_nxt = 4'(best_r);
          queued_nxt[best_r] = 1'b0;
          if (emode_r[best_r][1]) begin
            if (time_r >= bexp_r) begin
              drift_full = time_r - bexp_r;
            end else begin
              drift_full = TMAX - bexp_r + time_r;
            end
            drift_nxt = 32'(drift_full);
          end
        end
        opend_nxt = |queued_nxt;
        state_nxt = stt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = stt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= stt_pkg::ST_IDLE;
      time_r   <= '0;
      stamp_r  <= '0;
      ready_r  <= '0;
      active_r <= '0;
      queued_r <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        emode_r[i] <= '0;
      end
      rvalid_r <= 1'b0;
      ovalid_r <= 1'b0;
      opend_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      time_r   <= time_nxt;
      stamp_r  <= stamp_nxt;
      ready_r  <= ready_nxt;
      active_r <= active_nxt;
      queued_r <= queued_nxt;
      emode_r  <= emode_nxt;
      rvalid_r <= rvalid_nxt;
      ovalid_r <= ovalid_nxt;
      opend_r  <= opend_nxt;
    end
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    exists_r  <= exists_nxt;
    mode_in_r <= mode_in_nxt;
    per_in_r  <= per_in_nxt;
    lag_in_r  <= lag_in_nxt;
    pri_in_r  <= pri_in_nxt;
    rptr_r    <= rptr_nxt;
    rcnt_r    <= rcnt_nxt;
    cptr_r    <= cptr_nxt;
    count_r   <= count_nxt;
    found_r   <= found_nxt;
    best_r    <= best_nxt;
    bpri_r    <= bpri_nxt;
    bage_r    <= bage_nxt;
    bexp_r    <= bexp_nxt;
    ok_r      <= ok_nxt;
    err_r     <= err_nxt;
    opv_r     <= opv_nxt;
    opidx_r   <= opidx_nxt;
    drift_r   <= drift_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  assign busy               = (state_r != stt_pkg::ST_IDLE) || ovalid_r;
  assign out_valid          = ovalid_r;
  assign out_ok             = ok_r;
  assign out_error_code     = err_r;
  assign out_expired_count  = ocnt_r;
  assign out_expire_pending = opend_r;
  assign out_popped_valid   = opv_r;
  assign out_popped_index   = opidx_r;
  assign out_drift_ticks    = drift_r;
endmodule

[bench/stt_checker.sv]
// stt_checker: watches the command and result channels of software_timer_table,
// keeps its own timer table model and compares every result field by field
// depends on stt_pkg
module stt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_timer_index,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_period_ticks,
  input  logic [31:0] in_lag_ticks,
  input  logic [7:0]  in_priority_req,
  input  logic        out_valid,
  input  logic        out_ok,
  input  logic [1:0]  out_error_code,
  input  logic [4:0]  out_expired_count,
  input  logic        out_expire_pending,
  input  logic        out_popped_valid,
  input  logic [3:0]  out_popped_index,
  input  logic [31:0] out_drift_ticks,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          expiry_count,
  output int          pop_count
);
  typedef struct packed {
    logic        ok;
    logic [1:0]  error_code;
    logic [4:0]  expired_count;
    logic        expire_pending;
    logic        popped_valid;
    logic [3:0]  popped_index;
    logic [31:0] drift_ticks;
  } timer_answer_t;

  logic [31:0] now_ticks;
  logic [15:0] next_stamp;
  logic        created [16];
  logic        running [16];
  logic [1:0]  kind [16];
  logic        queued [16];
  logic [31:0] period [16];
  logic [31:0] match_at [16];
  logic [7:0]  prio [16];
  logic [31:0] expired_at [16];
  logic [15:0] stamp [16];

  timer_answer_t answers_due [$];

  function automatic void wipe_entry(int i);
    created[i] = 0; running[i] = 0; kind[i] = 0; queued[i] = 0;
    period[i] = 0; match_at[i] = 0; prio[i] = 0; expired_at[i] = 0; stamp[i] = 0;
  endfunction

  function automatic timer_answer_t apply_command(logic [2:0] op, logic [3:0] idx,
                                                   logic [1:0] md, logic [31:0] per,
                                                   logic [31:0] lag, logic [7:0] pr);
    timer_answer_t a;
    logic          found;
    int            best;
    logic [15:0]   best_age;
    logic [15:0]   age;
    a = '0;
    case (op)
      stt_pkg::OP_CREATE: begin
        if (created[idx]) begin
          a.error_code = stt_pkg::ERR_ALREADY;
        end else begin
          wipe_entry(int'(idx));
          created[idx] = 1; kind[idx] = md; period[idx] = per; prio[idx] = pr;
          a.ok = 1;
        end
      end
      stt_pkg::OP_DELETE, stt_pkg::OP_CONFIGURE, stt_pkg::OP_START, stt_pkg::OP_STOP: begin
        if (!created[idx]) begin
          a.error_code = stt_pkg::ERR_NOT_CREATED;
        end else if ((op == stt_pkg::OP_STOP) != running[idx]) begin
          a.error_code = stt_pkg::ERR_STATUS;
        end else begin
          a.ok = 1;
          if (op == stt_pkg::OP_DELETE) begin
            wipe_entry(int'(idx));
          end else if (op == stt_pkg::OP_CONFIGURE) begin
            period[idx] = per; prio[idx] = pr;
          end else if (op == stt_pkg::OP_START) begin
            match_at[idx] = now_ticks + period[idx] + lag;
            running[idx] = 1;
          end else begin
            queued[idx] = 0; running[idx] = 0;
          end
        end
      end
      stt_pkg::OP_TICK: begin
        now_ticks = now_ticks + 32'd1;
        for (int i = 0; i < 16; i++) begin
          if (created[i] && running[i] && match_at[i] == now_ticks) begin
            if (!queued[i]) begin
              queued[i] = 1; expired_at[i] = match_at[i]; stamp[i] = next_stamp;
              next_stamp = next_stamp + 16'd1;
              a.expired_count = a.expired_count + 5'd1;
            end
            if (kind[i][0]) match_at[i] = match_at[i] + period[i];
            else running[i] = 0;
          end
        end
        a.ok = 1;
      end
      stt_pkg::OP_POP: begin
        found = 0; best = 0; best_age = 0;
        for (int i = 0; i < 16; i++) begin
          if (queued[i]) begin
            age = next_stamp - stamp[i];
            if (!found || prio[i] < prio[best] || (prio[i] == prio[best] && age > best_age)) begin
              found = 1; best = i; best_age = age;
            end
          end
        end
        if (found) begin
          queued[best] = 0;
          a.ok = 1; a.popped_valid = 1; a.popped_index = best[3:0];
          if (kind[best][1]) begin
            if (now_ticks >= expired_at[best]) a.drift_ticks = now_ticks - expired_at[best];
            else a.drift_ticks = 32'hFFFF_FFFF - expired_at[best] + now_ticks;
          end
        end
      end
      default: ;
    endcase
    a.expire_pending = 0;
    for (int i = 0; i < 16; i++) if (queued[i]) a.expire_pending = 1;
    return a;
  endfunction

  timer_answer_t got, want;

  assign pending_count = answers_due.size();
  assign got = {out_ok, out_error_code, out_expired_count, out_expire_pending,
                out_popped_valid, out_popped_index, out_drift_ticks};

  always @(posedge clk) begin
    if (!rst_n) begin
      now_ticks <= 0;
      next_stamp <= 0;
      for (int i = 0; i < 16; i++) wipe_entry(i);
      answers_due.delete();
      fail_count <= 0; result_count <= 0; expiry_count <= 0; pop_count <= 0;
    end else begin
      if (out_valid) begin
        result_count <= result_count + 1;
        if (answers_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("result mismatch: expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        want = apply_command(in_opcode, in_timer_index, in_mode, in_period_ticks,
                             in_lag_ticks, in_priority_req);
        expiry_count <= expiry_count + int'(want.expired_count);
        if (want.popped_valid) pop_count <= pop_count + 1;
        answers_due.push_back(want);
      end
    end
  end
endmodule

[bench/testbench.sv]
// testbench: drives directed and random command transactions into
// software_timer_table; depends on stt_pkg, the block and stt_checker
module testbench;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_opcode = 0;
  logic [3:0]  in_timer_index = 0;
  logic [1:0]  in_mode = 0;
  logic [31:0] in_period_ticks = 0;
  logic [31:0] in_lag_ticks = 0;
  logic [7:0]  in_priority_req = 0;
  logic        out_valid, out_ok, out_expire_pending, out_popped_valid;
  logic [1:0]  out_error_code;
  logic [4:0]  out_expired_count;
  logic [3:0]  out_popped_index;
  logic [31:0] out_drift_ticks;
  int          fail_count, pending_count, result_count, expiry_count, pop_count;
  int          cycles = 0;
  int          idle_pct = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  software_timer_table dut (.*);
  stt_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic issue(logic [2:0] op, logic [3:0] idx, logic [1:0] md,
                       logic [31:0] per, logic [31:0] lag, logic [7:0] pr);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      start = 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    start = 1;
    in_opcode = op; in_timer_index = idx; in_mode = md;
    in_period_ticks = per; in_lag_ticks = lag; in_priority_req = pr;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_command();
    int          w;
    logic [2:0]  op;
    logic [31:0] per, lag;
    logic [7:0]  pr;
    w = $urandom_range(99);
    if (w < 14) op = stt_pkg::OP_CREATE;
    else if (w < 22) op = stt_pkg::OP_DELETE;
    else if (w < 29) op = stt_pkg::OP_CONFIGURE;
    else if (w < 44) op = stt_pkg::OP_START;
    else if (w < 51) op = stt_pkg::OP_STOP;
    else if (w < 84) op = stt_pkg::OP_TICK;
    else op = stt_pkg::OP_POP;
    per = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom;
    lag = ($urandom_range(99) < 80) ? $urandom_range(0, 4) : $urandom;
    pr = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(255));
    issue(op, 4'($urandom_range(15)), 2'($urandom_range(3)), per, lag, pr);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1;
    // directed: every operation and every error
    issue(stt_pkg::OP_POP, 0, 0, 1, 0, 0);
    issue(stt_pkg::OP_CREATE, 0, 3, 1, 0, 0);
    issue(stt_pkg::OP_CREATE, 0, 0, 1, 0, 0);
    issue(stt_pkg::OP_CREATE, 15, 0, 32'hFFFF_FFFF, 0, 8'hFF);
    issue(stt_pkg::OP_CONFIGURE, 15, 0, 2, 0, 8'hFF);
    issue(stt_pkg::OP_START, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_START, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_STOP, 1, 0, 0, 0, 0);
    issue(stt_pkg::OP_DELETE, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_CONFIGURE, 0, 0, 5, 0, 0);
    issue(stt_pkg::OP_TICK, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_TICK, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_POP, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_POP, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_START, 15, 0, 0, 32'hFFFF_FFFF, 0);
    issue(stt_pkg::OP_STOP, 15, 0, 0, 0, 0);
    issue(stt_pkg::OP_CREATE, 1, 1, 3, 0, 0);
    issue(stt_pkg::OP_START, 1, 0, 0, 2, 0);
    issue(stt_pkg::OP_START, 15, 0, 0, 0, 0);
    repeat (5) issue(stt_pkg::OP_TICK, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_POP, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_STOP, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_DELETE, 0, 0, 0, 0, 0);
    issue(stt_pkg::OP_DELETE, 2, 0, 0, 0, 0);
    for (int n = 0; n < 1800; n++) begin
      case (n / 450)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 25;
        default: idle_pct = 0;
      endcase
      random_command();
    end
    start = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d result transactions, %0d timer expirations, %0d pops",
             result_count, expiry_count, pop_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
